// ===== hdl/ber_real_binary_encoder_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef BER_REAL_BINARY_ENCODER_MACROS_SVH
`define BER_REAL_BINARY_ENCODER_MACROS_SVH

// A property checked on every rising edge while reset is released.
`define BER_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A property checked on every rising edge, during reset too.
`define BER_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ber_pkg.sv =====
package ber_pkg;

    localparam logic [7:0]  HDR_BINARY    = 8'h80;
    localparam logic [7:0]  HDR_SIGN      = 8'h40;
    localparam logic [7:0]  HDR_EXP_LONG  = 8'h01;
    localparam logic [7:0]  OCT_PLUS_INF  = 8'h40;
    localparam logic [7:0]  OCT_MINUS_INF = 8'h41;
    localparam logic [10:0] BEXP_SPECIAL  = 11'h7ff;
    localparam logic [11:0] EXP_BIAS_ADJ  = 12'd1075;
    localparam logic [2:0]  MANT_OCTETS   = 3'd7;

    typedef enum logic [1:0] {
        K_ZERO        = 2'd0,
        K_PLUS_INF    = 2'd1,
        K_MINUS_INF   = 2'd2,
        K_FINITE      = 2'd3
    } t_kind;

    typedef struct packed {
        logic load;
        logic shift_oct;
        logic shift_bit;
    } t_shift_ctl;

    typedef struct packed {
        logic  oct_low_zero;
        logic  bit_low_zero;
        logic  mlen_one;
        t_kind kind;
    } t_shift_stat;

    typedef struct packed {
        t_kind        kind;
        logic         sign;
        logic [11:0]  exp;
        logic [55:0]  mant;
        logic [2:0]   mlen;
    } t_enc;

endpackage

// ===== hdl/ber_shift.sv =====
module ber_shift (
    input  logic                 i_clk,
    input  logic [63:0]          i_bits,
    input  ber_pkg::t_shift_ctl  i_ctl,
    output ber_pkg::t_shift_stat o_stat,
    output ber_pkg::t_enc        o_enc
);
    import ber_pkg::*;

    logic [55:0] r_mant;
    logic [11:0] r_exp;
    logic [2:0]  r_mlen;
    logic        r_sign;
    t_kind       r_kind;

    logic [10:0] w_bexp;
    logic [51:0] w_frac;
    logic [10:0] w_bexp_eff;
    logic [11:0] w_exp0;
    logic [11:0] w_exp_inc;
    logic [11:0] w_exp_sum;
    t_kind       w_kind;

    always_comb begin
        w_bexp     = i_bits[62:52];
        w_frac     = i_bits[51:0];
        w_bexp_eff = (w_bexp == 11'd0) ? 11'd1 : w_bexp;
        w_exp0     = {1'b0, w_bexp_eff} - EXP_BIAS_ADJ;
        if (i_bits[62:0] == 63'd0) begin
            w_kind = K_ZERO;
        end else if (w_bexp == BEXP_SPECIAL) begin
            w_kind = (w_frac == 52'd0 && !i_bits[63]) ? K_PLUS_INF : K_MINUS_INF;
        end else begin
            w_kind = K_FINITE;
        end
        w_exp_inc = i_ctl.shift_oct ? 12'd8 : 12'd1;
        w_exp_sum = r_exp + w_exp_inc;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mant <= {3'b000, (w_bexp != 11'd0), w_frac};
            r_exp  <= w_exp0;
            r_mlen <= MANT_OCTETS;
            r_sign <= i_bits[63];
            r_kind <= w_kind;
        end else if (i_ctl.shift_oct) begin
            r_mant <= {8'h00, r_mant[55:8]};
            r_exp  <= w_exp_sum;
            r_mlen <= r_mlen - 3'd1;
        end else if (i_ctl.shift_bit) begin
            r_mant <= {1'b0, r_mant[55:1]};
            r_exp  <= w_exp_sum;
        end
    end

    assign o_stat.oct_low_zero = (r_mant[7:0] == 8'h00);
    assign o_stat.bit_low_zero = !r_mant[0];
    assign o_stat.mlen_one     = (r_mlen == 3'd1);
    assign o_stat.kind         = r_kind;

    assign o_enc.kind = r_kind;
    assign o_enc.sign = r_sign;
    assign o_enc.exp  = r_exp;
    assign o_enc.mant = r_mant;
    assign o_enc.mlen = r_mlen;

endmodule

// ===== hdl/ber_emit.sv =====
module ber_emit (
    input  logic          i_clk,
    input  ber_pkg::t_enc i_enc,
    input  logic          i_clear,
    input  logic          i_advance,
    output logic [7:0]    o_octet,
    output logic          o_last,
    output logic          o_empty_res,
    output logic [3:0]    o_content_length
);
    import ber_pkg::*;

    logic [3:0] r_idx;

    logic       w_short;
    logic [3:0] w_nhdr;
    logic [3:0] w_len;
    logic [3:0] w_j;
    logic [2:0] w_pos;
    logic [7:0] w_mant_oct;
    logic [7:0] w_exp_hi;
    logic [7:0] w_header;

    always_comb begin
        w_short  = (i_enc.exp[11:7] == 5'b00000) || (i_enc.exp[11:7] == 5'b11111);
        w_nhdr   = w_short ? 4'd2 : 4'd3;
        w_exp_hi = {{4{i_enc.exp[11]}}, i_enc.exp[11:8]};
        w_header = HDR_BINARY | (i_enc.sign ? HDR_SIGN : 8'h00)
                 | (w_short ? 8'h00 : HDR_EXP_LONG);
        w_j      = r_idx - w_nhdr;
        w_pos    = i_enc.mlen - 3'd1 - w_j[2:0];
        unique case (w_pos)
            3'd0:    w_mant_oct = i_enc.mant[7:0];
            3'd1:    w_mant_oct = i_enc.mant[15:8];
            3'd2:    w_mant_oct = i_enc.mant[23:16];
            3'd3:    w_mant_oct = i_enc.mant[31:24];
            3'd4:    w_mant_oct = i_enc.mant[39:32];
            3'd5:    w_mant_oct = i_enc.mant[47:40];
            3'd6:    w_mant_oct = i_enc.mant[55:48];
            default: w_mant_oct = 8'h00;
        endcase

        unique case (i_enc.kind)
            K_ZERO: begin
                w_len   = 4'd0;
                o_octet = 8'h00;
            end
            K_PLUS_INF: begin
                w_len   = 4'd1;
                o_octet = OCT_PLUS_INF;
            end
            K_MINUS_INF: begin
                w_len   = 4'd1;
                o_octet = OCT_MINUS_INF;
            end
            default: begin
                w_len = w_nhdr + {1'b0, i_enc.mlen};
                priority if (r_idx == 4'd0) begin
                    o_octet = w_header;
                end else if (r_idx == 4'd1) begin
                    o_octet = w_short ? i_enc.exp[7:0] : w_exp_hi;
                end else if (r_idx == 4'd2 && !w_short) begin
                    o_octet = i_enc.exp[7:0];
                end else begin
                    o_octet = w_mant_oct;
                end
            end
        endcase

        o_empty_res      = (i_enc.kind == K_ZERO);
        o_last           = (i_enc.kind == K_ZERO) || (r_idx == w_len - 4'd1);
        o_content_length = w_len;
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_idx <= 4'd0;
        end else if (i_advance) begin
            r_idx <= r_idx + 4'd1;
        end
    end

endmodule

// ===== hdl/ber_real_binary_encoder.sv =====
// Accepts one binary64 word, normalizes it in a shared shift unit, then sends octets.
// Finite values go through a octet shifts (0..6) and b bit shifts (0..7) in the shift unit,
// then n content octets (3..10); zero, infinity and NaN skip the shifts.
// The first octet is offered in S_EMIT, after S_OCT and, for finite values, S_BIT.
// Synchronous active-low reset returns the sequencer to idle with no word pending.
module ber_real_binary_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_value_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_octet,
    output logic        o_last,
    output logic        o_empty_res,
    output logic [3:0]  o_content_length
);
    import ber_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_OCT  = 4'b0010,
        S_BIT  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state      r_state;
    t_state      n_state;
    t_shift_ctl  w_ctl;
    t_shift_stat w_stat;
    t_enc        w_enc;
    logic        w_in_acc;
    logic        w_out_acc;

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = (r_state == S_EMIT);
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    always_comb begin
        w_ctl.load      = w_in_acc;
        w_ctl.shift_oct = (r_state == S_OCT) && (w_stat.kind == K_FINITE)
                        && w_stat.oct_low_zero && !w_stat.mlen_one;
        w_ctl.shift_bit = (r_state == S_BIT) && w_stat.bit_low_zero;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_OCT;
                end
            end
            S_OCT: begin
                if (w_stat.kind != K_FINITE) begin
                    n_state = S_EMIT;
                end else if (!w_ctl.shift_oct) begin
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                if (!w_stat.bit_low_zero) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_acc && o_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    ber_shift u_shift (
        .i_clk  (i_clk),
        .i_bits (i_value_bits),
        .i_ctl  (w_ctl),
        .o_stat (w_stat),
        .o_enc  (w_enc)
    );

    ber_emit u_emit (
        .i_clk            (i_clk),
        .i_enc            (w_enc),
        .i_clear          (w_in_acc),
        .i_advance        (w_out_acc),
        .o_octet          (o_octet),
        .o_last           (o_last),
        .o_empty_res      (o_empty_res),
        .o_content_length (o_content_length)
    );

endmodule

// ===== hdl/ber_chk.sv =====
`include "ber_real_binary_encoder_macros.svh"

module ber_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_octet,
    input logic        o_last,
    input logic        o_empty_res,
    input logic [3:0]  o_content_length
);

    `BER_ASSERT(a_valid_holds, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "word dropped")
    `BER_ASSERT(a_one_at_a_time, i_clk, i_rst_n, o_valid |-> !o_ready, "input open while busy")
    `BER_ASSERT(a_empty_form, i_clk, i_rst_n, o_valid && o_empty_res |-> o_last && (o_content_length == 4'd0), "bad empty word")
    `BER_ASSERT(a_length_range, i_clk, i_rst_n, o_valid && !o_empty_res |-> (o_content_length != 4'd0) && (o_content_length <= 4'd10), "bad length")
    `BER_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid && o_ready, "not idle after reset")

endmodule

bind ber_real_binary_encoder ber_chk u_chk (.*);
